// ----- rtl/core/calendar_date_adder_macros.svh -----
// Assertion macros shared by the date adder RTL.
`ifndef CALENDAR_DATE_ADDER_MACROS_SVH
`define CALENDAR_DATE_ADDER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CDA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("calendar_date_adder: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CDA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("calendar_date_adder: check failed");

`endif

// ----- rtl/core/cda_pkg.sv -----
package cda_pkg;

	localparam int YEAR_BITS   = 14;
	localparam int AMOUNT_BITS = 12;

	// Width of the constant divider operand: a year, or month index plus amount.
	localparam int DIV_W  = (YEAR_BITS > AMOUNT_BITS + 1) ? YEAR_BITS : AMOUNT_BITS + 1;
	localparam int DIV_SH = DIV_W + 5;
	localparam int K_W    = DIV_SH - 3;
	localparam int PROD_W = DIV_W + K_W;

	// Day accumulator must hold a day of up to 31 plus a full amount.
	localparam int DAY_W = ((AMOUNT_BITS > 5) ? AMOUNT_BITS : 5) + 1;

	localparam logic [K_W-1:0]       RECIP_12   = K_W'((2 ** DIV_SH) / 12);
	localparam logic [K_W-1:0]       RECIP_25   = K_W'((2 ** DIV_SH) / 25);
	localparam logic [DIV_W-1:0]     DIVISOR_12 = DIV_W'(12);
	localparam logic [DIV_W-1:0]     DIVISOR_25 = DIV_W'(25);

	localparam logic [YEAR_BITS-1:0] YEAR_MAX   = '1;
	localparam logic [YEAR_BITS-1:0] RESET_YEAR = YEAR_BITS'(2022);
	localparam logic [4:0]           RESET_R25  = 5'(int'(RESET_YEAR) % 25);
	localparam logic [3:0]           RESET_MONTH = 4'd1;
	localparam logic [DAY_W-1:0]     RESET_DAY  = DAY_W'(12);

	localparam logic [3:0] MONTHS_PER_YEAR = 4'd12;
	localparam logic [4:0] MAX_DAY         = 5'd31;
	localparam logic [4:0] R25_LIMIT       = 5'd25;

	typedef enum logic [1:0] {
		ACT_LOAD   = 2'd0,
		ACT_DAYS   = 2'd1,
		ACT_MONTHS = 2'd2,
		ACT_YEARS  = 2'd3
	} action_t;

	typedef enum logic {
		DIV_BY_12 = 1'b0,
		DIV_BY_25 = 1'b1
	} div_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DAY_STEP,
		ST_MON_MUL,
		ST_MON_FIX,
		ST_LEAP_MUL,
		ST_LEAP_FIX
	} state_t;

	// Leap when divisible by 4, except centuries that are not divisible by 400.
	// Divisible by 100 means by 4 and 25; by 400 means by 16 and 25.
	function automatic logic is_leap(input logic [3:0] y_lo, input logic [4:0] r25);
		return (y_lo[1:0] == 2'd0) && ((r25 != 5'd0) || (y_lo == 4'd0));
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m) inside
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			4'd2:                    len = leap ? 5'd29 : 5'd28;
			default:                 len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

// ----- rtl/core/cda_div.sv -----
// Divides by 12 or 25 with a reciprocal multiply. The operand and select
// must be held for two cycles; quotient and remainder are valid once the estimate is registered.
module cda_div (
	input  logic                       clk,
	input  logic [cda_pkg::DIV_W-1:0]  operand,
	input  cda_pkg::div_sel_t          sel,
	output logic [cda_pkg::DIV_W-1:0]  quotient,
	output logic [4:0]                 remainder
);
	import cda_pkg::*;

	logic [K_W-1:0]    recip;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] prod_sh;
	logic [DIV_W-1:0]  q_est_s1;
	div_sel_t          sel_s1;
	logic [DIV_W-1:0]  divisor;
	logic [DIV_W-1:0]  q_mul;
	logic [DIV_W-1:0]  rem_raw;

	always_comb begin
		recip   = (sel == DIV_BY_12) ? RECIP_12 : RECIP_25;
		prod    = PROD_W'(operand) * PROD_W'(recip);
		prod_sh = prod >> DIV_SH;
	end

	always_ff @(posedge clk) begin
		q_est_s1 <= prod_sh[DIV_W-1:0];
		sel_s1   <= sel;
	end

	// The estimate is never high and at most one low, so one correction is enough.
	always_comb begin
		divisor = (sel_s1 == DIV_BY_12) ? DIVISOR_12 : DIVISOR_25;
		q_mul   = q_est_s1 * divisor;
		rem_raw = operand - q_mul;
		if (rem_raw >= divisor) begin
			quotient  = q_est_s1 + DIV_W'(1);
			remainder = 5'(rem_raw - divisor);
		end else begin
			quotient  = q_est_s1;
			remainder = 5'(rem_raw);
		end
	end

endmodule

// ----- rtl/core/calendar_date_adder.sv -----
// Gregorian date register with load and add-days/months/years commands. A
// word is taken when start is high and busy is low; its result date appears
// on the outputs for exactly one cycle with done high, and must be captured
// then since the block does not wait. A load or year add passes through the
// ST_LEAP_MUL and ST_LEAP_FIX states, which update the year's remainder mod
// 25 through the shared reciprocal divider; a month add first passes through
// ST_MON_MUL and ST_MON_FIX to divide the month index by 12. A day add steps
// the day counter down one month per cycle until the day fits. A new start
// may be given in the cycle where done is high.
`include "calendar_date_adder_macros.svh"

module calendar_date_adder (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [1:0]                       action,
	input  logic [cda_pkg::YEAR_BITS-1:0]    load_year,
	input  logic [3:0]                       load_month,
	input  logic [4:0]                       load_day,
	input  logic [cda_pkg::AMOUNT_BITS-1:0]  amount,
	output logic                             busy,
	output logic                             done,
	output logic [cda_pkg::YEAR_BITS-1:0]    year_out,
	output logic [3:0]                       month_out,
	output logic [4:0]                       day_out,
	output logic                             year_overflow
);
	import cda_pkg::*;

	state_t                 state_q, state_nxt;
	logic [YEAR_BITS-1:0]   year_q;
	logic [3:0]             month_q;
	logic [DAY_W-1:0]       day_q;
	logic [4:0]             r25_q;
	logic                   ovf_q;
	logic                   done_q;
	logic [DIV_W-1:0]       op_q;
	div_sel_t               sel_q;

	logic                   accept;
	logic                   fin;
	action_t                act;
	logic [DIV_W-1:0]       quotient;
	logic [4:0]             remainder;
	logic                   leap_now;
	logic [4:0]             len;
	logic                   day_fits;
	logic [DIV_W-1:0]       addend;
	logic [DIV_W:0]         ysum;
	logic                   ysat;
	logic [YEAR_BITS-1:0]   year_new;
	logic [3:0]             lmonth;
	logic [4:0]             lday;
	logic [DIV_W-1:0]       mon_index;

	cda_div u_div (
		.clk       (clk),
		.operand   (op_q),
		.sel       (sel_q),
		.quotient  (quotient),
		.remainder (remainder)
	);

	assign act    = action_t'(action);
	assign accept = start && !busy;

	always_comb begin
		leap_now = is_leap(year_q[3:0], r25_q);
		len      = month_len(month_q, leap_now);
		day_fits = day_q <= DAY_W'(len);
	end

	// Saturating year add, shared by the year add and the month carry.
	always_comb begin
		addend   = (state_q == ST_MON_FIX) ? quotient : DIV_W'(amount);
		ysum     = (DIV_W + 1)'(year_q) + (DIV_W + 1)'(addend);
		ysat     = ysum > (DIV_W + 1)'(YEAR_MAX);
		year_new = ysat ? YEAR_MAX : ysum[YEAR_BITS-1:0];
	end

	always_comb begin
		if (load_month == 4'd0) begin
			lmonth = 4'd1;
		end else if (load_month > MONTHS_PER_YEAR) begin
			lmonth = MONTHS_PER_YEAR;
		end else begin
			lmonth = load_month;
		end
		lday      = (load_day == 5'd0) ? 5'd1 : load_day;
		mon_index = DIV_W'(month_q - 4'd1) + DIV_W'(amount);
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (act)
						ACT_DAYS:   state_nxt = ST_DAY_STEP;
						ACT_MONTHS: state_nxt = ST_MON_MUL;
						default:    state_nxt = ST_LEAP_MUL;
					endcase
				end
			end
			ST_DAY_STEP: begin
				if (day_fits) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_MON_MUL:  state_nxt = ST_MON_FIX;
			ST_MON_FIX:  state_nxt = ST_LEAP_MUL;
			ST_LEAP_MUL: state_nxt = ST_LEAP_FIX;
			ST_LEAP_FIX: state_nxt = ST_IDLE;
			default:     state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		busy = state_q != ST_IDLE;
		case (state_q)
			ST_DAY_STEP: fin = day_fits;
			ST_LEAP_FIX: fin = 1'b1;
			default:     fin = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			year_q  <= RESET_YEAR;
			month_q <= RESET_MONTH;
			day_q   <= RESET_DAY;
			r25_q   <= RESET_R25;
			ovf_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= fin;
			if (accept) begin
				ovf_q <= (act == ACT_YEARS) ? ysat : 1'b0;
				case (act)
					ACT_LOAD: begin
						year_q  <= load_year;
						month_q <= lmonth;
						day_q   <= DAY_W'(lday);
					end
					ACT_DAYS: begin
						day_q <= day_q + DAY_W'(amount);
					end
					ACT_MONTHS: begin
					end
					default: begin
						year_q <= year_new;
					end
				endcase
			end
			case (state_q)
				ST_DAY_STEP: begin
					if (!day_fits) begin
						day_q <= day_q - DAY_W'(len);
						if (month_q == MONTHS_PER_YEAR) begin
							month_q <= 4'd1;
							if (year_q == YEAR_MAX) begin
								ovf_q <= 1'b1;
							end else begin
								year_q <= year_q + YEAR_BITS'(1);
								r25_q  <= (r25_q == R25_LIMIT - 5'd1) ? 5'd0 : r25_q + 5'd1;
							end
						end else begin
							month_q <= month_q + 4'd1;
						end
					end
				end
				ST_MON_FIX: begin
					month_q <= remainder[3:0] + 4'd1;
					year_q  <= year_new;
					ovf_q   <= ysat;
				end
				ST_LEAP_FIX: begin
					r25_q <= remainder;
				end
				default: begin
				end
			endcase
		end
	end

	// Divider operand: the month index at the start of a month add, else the new year.
	always_ff @(posedge clk) begin
		if (accept) begin
			case (act)
				ACT_LOAD: begin
					op_q  <= DIV_W'(load_year);
					sel_q <= DIV_BY_25;
				end
				ACT_MONTHS: begin
					op_q  <= mon_index;
					sel_q <= DIV_BY_12;
				end
				default: begin
					op_q  <= DIV_W'(year_new);
					sel_q <= DIV_BY_25;
				end
			endcase
		end else if (state_q == ST_MON_FIX) begin
			op_q  <= DIV_W'(year_new);
			sel_q <= DIV_BY_25;
		end
	end

	assign done          = done_q;
	assign year_out      = year_q;
	assign month_out     = month_q;
	assign day_out       = day_q[4:0];
	assign year_overflow = ovf_q;

	`CDA_ASSERT_IMP(a_done_not_busy, clk, arst_n, done_q, !busy)
	`CDA_ASSERT_NXT(a_start_goes_busy, clk, arst_n, start && !busy, busy)
	`CDA_ASSERT_IMP(a_month_range, clk, arst_n, !busy, month_q >= 4'd1 && month_q <= MONTHS_PER_YEAR)
	`CDA_ASSERT_IMP(a_day_range, clk, arst_n, !busy, day_q >= DAY_W'(1) && day_q <= DAY_W'(MAX_DAY))
	`CDA_ASSERT_IMP(a_r25_range, clk, arst_n, 1'b1, r25_q < R25_LIMIT)

endmodule

// ----- test/tb_calendar_date_adder.sv -----
`timescale 1ns / 100ps

module tb_calendar_date_adder;

	import cda_pkg::*;

	localparam int YEAR_TOP = (1 << YEAR_BITS) - 1;
	localparam int DAY_MASK = 31;

	typedef struct {
		int unsigned year;
		int unsigned month;
		int unsigned day;
		bit          ovf;
	} date_word_t;

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic [1:0]             action;
	logic [YEAR_BITS-1:0]   load_year;
	logic [3:0]             load_month;
	logic [4:0]             load_day;
	logic [AMOUNT_BITS-1:0] amount;
	logic                   busy;
	logic                   done;
	logic [YEAR_BITS-1:0]   year_out;
	logic [3:0]             month_out;
	logic [4:0]             day_out;
	logic                   year_overflow;

	// Calendar state as the testbench tracks it.
	int unsigned cal_year;
	int unsigned cal_month;
	int unsigned cal_day;
	bit          cal_ovf;

	date_word_t  pending_dates[$];
	int          error_count;
	bit          gaps_on;

	calendar_date_adder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.action       (action),
		.load_year    (load_year),
		.load_month   (load_month),
		.load_day     (load_day),
		.amount       (amount),
		.busy         (busy),
		.done         (done),
		.year_out     (year_out),
		.month_out    (month_out),
		.day_out      (day_out),
		.year_overflow(year_overflow)
	);

	initial begin
		clk = 1'b0;
	end

	always #4 clk = ~clk;

	function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
		bit leap;
		leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		case (m)
			4, 6, 9, 11: return 30;
			2:           return leap ? 29 : 28;
			default:     return 31;
		endcase
	endfunction

	function automatic void carry_years(int unsigned n);
		int unsigned sum;
		sum = cal_year + n;
		if (sum > YEAR_TOP) begin
			sum = YEAR_TOP;
			cal_ovf = 1'b1;
		end
		cal_year = sum;
	endfunction

	function automatic void carry_months(int unsigned n);
		int unsigned idx;
		idx = (cal_month - 1) + n;
		cal_month = (idx % 12) + 1;
		carry_years(idx / 12);
	endfunction

	// Applies one command word to the tracked calendar and returns the date after it.
	function automatic date_word_t advance_calendar(action_t act, logic [YEAR_BITS-1:0] y,
			logic [3:0] m, logic [4:0] d, logic [AMOUNT_BITS-1:0] n);
		date_word_t res;
		int unsigned len;
		cal_ovf = 1'b0;
		case (act)
			ACT_LOAD: begin
				cal_year  = 32'(y);
				cal_month = (m == 0) ? 1 : ((m > 12) ? 12 : 32'(m));
				cal_day   = (d == 0) ? 1 : 32'(d);
			end
			ACT_DAYS: begin
				cal_day = cal_day + 32'(n);
				len = days_in_month(cal_month, cal_year);
				while (cal_day > len) begin
					cal_day = cal_day - len;
					carry_months(1);
					len = days_in_month(cal_month, cal_year);
				end
			end
			ACT_MONTHS: carry_months(32'(n));
			default:    carry_years(32'(n));
		endcase
		res.year  = cal_year & YEAR_TOP;
		res.month = cal_month & 15;
		res.day   = cal_day & DAY_MASK;
		res.ovf   = cal_ovf;
		return res;
	endfunction

	task automatic check_field(string name, int unsigned exp_val, int unsigned got_val);
		if (exp_val != got_val) begin
			error_count++;
			if (error_count <= 40)
				$display("%0t: %s expected %0d, got %0d", $time, name, exp_val, got_val);
		end
	endtask

	always @(posedge clk) begin
		date_word_t exp_date;
		if (arst_n && done) begin
			if (pending_dates.size() == 0) begin
				error_count++;
				if (error_count <= 40)
					$display("%0t: result word with none pending: %0d-%0d-%0d ovf %0b",
						$time, year_out, month_out, day_out, year_overflow);
			end else begin
				exp_date = pending_dates.pop_front();
				check_field("year_out", exp_date.year, 32'(year_out));
				check_field("month_out", exp_date.month, 32'(month_out));
				check_field("day_out", exp_date.day, 32'(day_out));
				check_field("year_overflow", 32'(exp_date.ovf), 32'(year_overflow));
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_word(action_t act, logic [YEAR_BITS-1:0] y, logic [3:0] m,
			logic [4:0] d, logic [AMOUNT_BITS-1:0] n);
		if (gaps_on && $urandom_range(99) < 15) begin
			start = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		start      = 1'b1;
		action     = act;
		load_year  = y;
		load_month = m;
		load_day   = d;
		amount     = n;
		do
			@(posedge clk);
		while (busy);
		pending_dates.push_back(advance_calendar(act, y, m, d, n));
		@(negedge clk);
	endtask

	task automatic test_reset_state();
		send_word(ACT_DAYS, '0, '0, '0, '0);
	endtask

	task automatic test_load_limits();
		send_word(ACT_LOAD, '0, 4'd0, 5'd0, '1);
		send_word(ACT_LOAD, '1, 4'd15, 5'd31, '0);
		send_word(ACT_LOAD, 14'd2000, 4'd13, 5'd0, '0);
	endtask

	task automatic test_day_carry();
		send_word(ACT_LOAD, 14'd2000, 4'd2, 5'd28, '0);
		send_word(ACT_DAYS, '0, '0, '0, 12'd1);
		send_word(ACT_DAYS, '0, '0, '0, 12'd1);
		// A century year that is not a multiple of 400 has a short February.
		send_word(ACT_LOAD, 14'd1900, 4'd2, 5'd28, '0);
		send_word(ACT_DAYS, '0, '0, '0, 12'd1);
		send_word(ACT_LOAD, 14'd2023, 4'd12, 5'd31, '0);
		send_word(ACT_DAYS, '0, '0, '0, 12'd1);
		send_word(ACT_DAYS, '0, '0, '0, '1);
	endtask

	task automatic test_month_add();
		send_word(ACT_LOAD, 14'd2021, 4'd1, 5'd31, '0);
		// The day is kept past the month length until the next day add.
		send_word(ACT_MONTHS, '0, '0, '0, 12'd1);
		send_word(ACT_DAYS, '0, '0, '0, 12'd0);
		send_word(ACT_MONTHS, '0, '0, '0, '1);
	endtask

	task automatic test_year_add();
		send_word(ACT_LOAD, 14'd2024, 4'd2, 5'd29, '0);
		send_word(ACT_YEARS, '0, '0, '0, 12'd1);
		send_word(ACT_YEARS, '0, '0, '0, '1);
	endtask

	task automatic test_year_saturation();
		send_word(ACT_LOAD, 14'd16380, 4'd6, 5'd15, '0);
		send_word(ACT_YEARS, '0, '0, '0, '1);
		send_word(ACT_LOAD, '1, 4'd12, 5'd31, '0);
		send_word(ACT_DAYS, '0, '0, '0, 12'd1);
		send_word(ACT_LOAD, '1, 4'd11, 5'd1, '0);
		send_word(ACT_MONTHS, '0, '0, '0, 12'd2);
	endtask

	task automatic test_random_words(int count);
		action_t                act;
		logic [YEAR_BITS-1:0]   y;
		logic [3:0]             m;
		logic [4:0]             d;
		logic [AMOUNT_BITS-1:0] n;
		int                     pick;
		for (int i = 0; i < count; i++) begin
			// A long run in the middle goes back to back.
			gaps_on = (i < count * 2 / 5) || (i >= count * 3 / 5);
			y = YEAR_BITS'($urandom_range(YEAR_TOP));
			m = 4'($urandom_range(15));
			d = 5'($urandom_range(31));
			n = AMOUNT_BITS'($urandom_range((1 << AMOUNT_BITS) - 1));
			pick = $urandom_range(99);
			if (pick < 20) begin
				act = ACT_LOAD;
				case ($urandom_range(9))
					0, 1, 2, 3: y = YEAR_BITS'($urandom_range(YEAR_TOP));
					4, 5, 6:    y = YEAR_BITS'($urandom_range(2500, 1582));
					7:          y = YEAR_BITS'($urandom_range(40) * 400);
					8:          y = YEAR_BITS'(YEAR_TOP - $urandom_range(20));
					default:    y = YEAR_BITS'($urandom_range(163) * 100);
				endcase
				if ($urandom_range(9) != 0)
					m = 4'($urandom_range(12, 1));
				if ($urandom_range(9) == 0)
					d = 5'($urandom_range(31));
				else if ($urandom_range(1))
					d = 5'($urandom_range(31, 25));
				else
					d = 5'($urandom_range(31, 1));
			end else if (pick < 60) begin
				act = ACT_DAYS;
				case ($urandom_range(9))
					0:          n = AMOUNT_BITS'($urandom_range((1 << AMOUNT_BITS) - 1));
					1, 2, 3:    n = AMOUNT_BITS'($urandom_range(400));
					default:    n = AMOUNT_BITS'($urandom_range(40));
				endcase
			end else if (pick < 80) begin
				act = ACT_MONTHS;
				if ($urandom_range(1))
					n = AMOUNT_BITS'($urandom_range(24));
			end else begin
				act = ACT_YEARS;
				if ($urandom_range(9) < 7)
					n = AMOUNT_BITS'($urandom_range(50));
			end
			send_word(act, y, m, d, n);
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		action      = ACT_LOAD;
		load_year   = '0;
		load_month  = '0;
		load_day    = '0;
		amount      = '0;
		error_count = 0;
		gaps_on     = 1'b1;
		cal_year    = 2022;
		cal_month   = 1;
		cal_day     = 12;
		cal_ovf     = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_state();
		test_load_limits();
		test_day_carry();
		test_month_add();
		test_year_add();
		test_year_saturation();
		test_random_words(1800);

		start = 1'b0;
		while (pending_dates.size() != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
		if (error_count == 0 && pending_dates.size() == 0)
			$display("tb_calendar_date_adder OK");
		else
			$display("tb_calendar_date_adder NOT OK");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("%0t: timeout with %0d words pending", $time, pending_dates.size());
		$display("tb_calendar_date_adder NOT OK");
		$finish;
	end

endmodule
